### hw/rtl/ssac_pkg.sv
package ssac_pkg;

  localparam int TABLE_ENTRIES = 1024;
  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int USED_W = $clog2(TABLE_ENTRIES + 1);

  localparam logic [15:0] MIN_FRAME_BYTES = 16'd34;
  localparam logic [4:0] SHIFT_RESET = 5'd3;

  typedef enum logic [2:0] {
    ST_NOT_SAMPLED = 3'd0,
    ST_SHORT       = 3'd1,
    ST_INCREMENTED = 3'd2,
    ST_INSERTED    = 3'd3,
    ST_FULL        = 3'd4,
    ST_READ_HIT    = 3'd5,
    ST_READ_MISS   = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_LOOK,
    BK_CMP
  } back_state_t;

  // A word from the front part; direct words already carry their final status.
  typedef struct packed {
    logic        direct;
    logic        rd;
    status_t     status;
    logic [31:0] addr;
  } cmd_t;

  typedef struct packed {
    status_t     status;
    logic [63:0] count;
  } result_t;

endpackage

### hw/rtl/ssac_front.sv
module ssac_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  logic             req_type,
  input  logic [31:0]      random_word,
  input  logic [15:0]      frame_length,
  input  logic [31:0]      source_address,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [4:0]       cfg_data,
  output logic             cmd_valid,
  output ssac_pkg::cmd_t   cmd,
  input  logic             cmd_pop
);

  logic [4:0]     sample_shift;
  ssac_pkg::cmd_t q [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     cnt;
  logic [31:0]    mask;
  ssac_pkg::cmd_t cls;
  logic           do_push;

  assign cfg_ready = 1'b1;
  assign full = (cnt == 2'd2);
  assign do_push = push && !full;
  assign cmd_valid = (cnt != 2'd0);
  assign cmd = q[rd_ptr];

  always_comb begin
    mask = (32'd1 << sample_shift) - 32'd1;
    cls.rd = req_type;
    cls.addr = source_address;
    cls.direct = 1'b0;
    cls.status = ssac_pkg::ST_NOT_SAMPLED;
    if (!req_type) begin
      if ((random_word & mask) != 32'd0) begin
        cls.direct = 1'b1;
        cls.status = ssac_pkg::ST_NOT_SAMPLED;
      end else if (frame_length < ssac_pkg::MIN_FRAME_BYTES) begin
        cls.direct = 1'b1;
        cls.status = ssac_pkg::ST_SHORT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_shift <= ssac_pkg::SHIFT_RESET;
    end else if (cfg_valid) begin
      sample_shift <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q[wr_ptr] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (cmd_pop) begin
        rd_ptr <= !rd_ptr;
      end
      cnt <= cnt + {1'b0, do_push} - {1'b0, cmd_pop};
    end
  end

endmodule

### hw/rtl/ssac_back.sv
module ssac_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cmd_valid,
  input  ssac_pkg::cmd_t                cmd,
  output logic                          cmd_pop,
  input  logic                          out_full,
  output logic                          res_valid,
  output ssac_pkg::result_t             res,
  output logic [ssac_pkg::USED_W-1:0]   used
);

  localparam int IW = ssac_pkg::IDX_W;
  localparam int UW = ssac_pkg::USED_W;

  logic [31:0] key_mem [ssac_pkg::TABLE_ENTRIES];
  logic [63:0] cnt_mem [ssac_pkg::TABLE_ENTRIES];

  ssac_pkg::back_state_t state, state_next;
  logic [IW-1:0] idx, idx_next;
  logic [UW-1:0] used_next;
  logic          op_rd;
  logic [31:0]   op_addr;
  logic          lat_rd;
  logic [31:0]   lat_addr;
  logic [31:0]   key_rd;
  logic [63:0]   cnt_rd;
  logic          wr_cnt_en;
  logic          wr_key_en;
  logic [IW-1:0] wr_idx;
  logic [63:0]   wr_cnt;
  logic          do_miss;
  logic          last;

  assign op_rd = (state == ssac_pkg::BK_IDLE) ? cmd.rd : lat_rd;
  assign op_addr = (state == ssac_pkg::BK_IDLE) ? cmd.addr : lat_addr;
  assign last = ((UW'(idx) + UW'(1)) == used);

  always_comb begin
    state_next = state;
    idx_next = idx;
    used_next = used;
    cmd_pop = 1'b0;
    res_valid = 1'b0;
    res.status = ssac_pkg::ST_NOT_SAMPLED;
    res.count = 64'd0;
    wr_cnt_en = 1'b0;
    wr_key_en = 1'b0;
    wr_idx = idx;
    wr_cnt = cnt_rd + 64'd1;
    do_miss = 1'b0;
    case (state)
      ssac_pkg::BK_IDLE: begin
        if (cmd_valid && !out_full) begin
          cmd_pop = 1'b1;
          if (cmd.direct) begin
            res_valid = 1'b1;
            res.status = cmd.status;
          end else if (used == UW'(0)) begin
            do_miss = 1'b1;
          end else begin
            idx_next = '0;
            state_next = ssac_pkg::BK_LOOK;
          end
        end
      end
      ssac_pkg::BK_LOOK: begin
        state_next = ssac_pkg::BK_CMP;
      end
      ssac_pkg::BK_CMP: begin
        if (key_rd == lat_addr) begin
          if (!out_full) begin
            res_valid = 1'b1;
            state_next = ssac_pkg::BK_IDLE;
            if (lat_rd) begin
              res.status = ssac_pkg::ST_READ_HIT;
              res.count = cnt_rd;
            end else begin
              res.status = ssac_pkg::ST_INCREMENTED;
              res.count = cnt_rd + 64'd1;
              wr_cnt_en = 1'b1;
            end
          end
        end else if (last) begin
          if (!out_full) begin
            do_miss = 1'b1;
            state_next = ssac_pkg::BK_IDLE;
          end
        end else begin
          idx_next = idx + IW'(1);
          state_next = ssac_pkg::BK_LOOK;
        end
      end
      default: begin
        state_next = ssac_pkg::BK_IDLE;
      end
    endcase

    // An unknown address that is counted goes to the next free entry, if any, which is always the fill count.
    if (do_miss) begin
      res_valid = 1'b1;
      if (op_rd) begin
        res.status = ssac_pkg::ST_READ_MISS;
      end else if (used == UW'(ssac_pkg::TABLE_ENTRIES)) begin
        res.status = ssac_pkg::ST_FULL;
      end else begin
        res.status = ssac_pkg::ST_INSERTED;
        res.count = 64'd1;
        wr_idx = used[IW-1:0];
        wr_cnt = 64'd1;
        wr_cnt_en = 1'b1;
        wr_key_en = 1'b1;
        used_next = used + UW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ssac_pkg::BK_IDLE;
      used <= '0;
    end else begin
      state <= state_next;
      used <= used_next;
    end
  end

  always_ff @(posedge clk) begin
    idx <= idx_next;
    if (state == ssac_pkg::BK_IDLE) begin
      lat_rd <= cmd.rd;
      lat_addr <= cmd.addr;
    end
  end

  always_ff @(posedge clk) begin
    key_rd <= key_mem[idx_next];
    cnt_rd <= cnt_mem[idx_next];
    if (wr_key_en) begin
      key_mem[wr_idx] <= op_addr;
    end
    if (wr_cnt_en) begin
      cnt_mem[wr_idx] <= wr_cnt;
    end
  end

endmodule

### hw/rtl/ssac_out_q.sv
module ssac_out_q (
  input  logic                clk,
  input  logic                rst,
  input  logic                res_valid,
  input  ssac_pkg::result_t   res,
  output logic                out_full,
  output logic                empty,
  input  logic                pop,
  output ssac_pkg::result_t   head
);

  ssac_pkg::result_t q [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] cnt;
  logic       do_pop;

  assign out_full = (cnt == 2'd2);
  assign empty = (cnt == 2'd0);
  assign do_pop = pop && !empty;
  assign head = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (res_valid) begin
      q[wr_ptr] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (res_valid) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      cnt <= cnt + {1'b0, res_valid} - {1'b0, do_pop};
    end
  end

endmodule

### hw/rtl/sampled_source_address_counter_top.sv
// Channel  | Direction | Handshake              | Word
// input    | in        | push / full            | req_type, random_word, frame_length,
//          |           |                        | source_address
// result   | out       | empty / pop            | status, count_value
// config   | in        | cfg_valid / cfg_ready  | cfg_data (sample_shift)
//
// Unsampled and short frames, and any word while the table is empty, are answered by the
// back part straight from its idle state, without a lookup.
// A lookup walks the key memory one entry at a time (read, then compare), visiting
// up to used entries before it reports a miss.
// Synchronous reset empties both queues and the table; no clearing pass is needed.
// Two-word queues on each side let input and result stall independently.
module sampled_source_address_counter_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic        req_type,
  input  logic [31:0] random_word,
  input  logic [15:0] frame_length,
  input  logic [31:0] source_address,
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  status,
  output logic [63:0] count_value,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [4:0]  cfg_data
);

  logic                          cmd_valid;
  ssac_pkg::cmd_t                cmd;
  logic                          cmd_pop;
  logic                          out_full;
  logic                          res_valid;
  ssac_pkg::result_t             res;
  ssac_pkg::result_t             head;
  logic [ssac_pkg::USED_W-1:0]   used;

  ssac_front u_front (
    .clk(clk), .rst(rst), .push(push), .full(full), .req_type(req_type),
    .random_word(random_word), .frame_length(frame_length),
    .source_address(source_address), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_data(cfg_data), .cmd_valid(cmd_valid), .cmd(cmd), .cmd_pop(cmd_pop)
  );

  ssac_back u_back (
    .clk(clk), .rst(rst), .cmd_valid(cmd_valid), .cmd(cmd), .cmd_pop(cmd_pop),
    .out_full(out_full), .res_valid(res_valid), .res(res), .used(used)
  );

  ssac_out_q u_out_q (
    .clk(clk), .rst(rst), .res_valid(res_valid), .res(res), .out_full(out_full),
    .empty(empty), .pop(pop), .head(head)
  );

  assign status = head.status;
  assign count_value = head.count;

  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    used <= ssac_pkg::USED_W'(ssac_pkg::TABLE_ENTRIES))
    else $error("fill count beyond table size");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !out_full)
    else $error("result written into a full queue");

  a_pop_needs_word: assert property (@(posedge clk) disable iff (rst)
    cmd_pop |-> cmd_valid)
    else $error("command popped from an empty queue");

  a_used_step: assert property (@(posedge clk) disable iff (rst)
    used != $past(used) |-> used == $past(used) + ssac_pkg::USED_W'(1))
    else $error("fill count moved by other than one");

endmodule

### sim/sampled_source_address_counter_top_test.sv
module sampled_source_address_counter_top_test;

  timeunit 1ns;
  timeprecision 1ps;

  logic        clk;
  logic        rst;
  logic        push;
  logic        full;
  logic        req_type;
  logic [31:0] random_word;
  logic [15:0] frame_length;
  logic [31:0] source_address;
  logic        empty;
  logic        pop;
  logic [2:0]  status;
  logic [63:0] count_value;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [4:0]  cfg_data;

  sampled_source_address_counter_top i_dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .req_type(req_type),
    .random_word(random_word), .frame_length(frame_length),
    .source_address(source_address), .empty(empty), .pop(pop), .status(status),
    .count_value(count_value), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  // Our own copy of the counter table and the sampling shift.
  logic [4:0]  shift_q;
  logic        key_used [ssac_pkg::TABLE_ENTRIES];
  logic [31:0] key_addr [ssac_pkg::TABLE_ENTRIES];
  logic [63:0] key_count [ssac_pkg::TABLE_ENTRIES];
  int          used_cnt;

  ssac_pkg::result_t expected_q [$];
  int          errors;
  int          n_sent;
  int          n_checked;
  int          status_seen [7];
  int          send_idle_pct;
  int          recv_idle_pct;
  int          hold_req;
  int          hold_seen;
  int          hold_left;
  logic [31:0] addr_pool [24];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #200ms;
    $display("timeout at %0t", $time);
    $display("** sampled_source_address_counter_top: FAILED **");
    $finish;
  end

  function automatic ssac_pkg::result_t count_word(logic rd, logic [31:0] rnd,
                                                   logic [15:0] len, logic [31:0] addr);
    ssac_pkg::result_t r;
    int hit;
    int free_idx;
    hit = -1;
    free_idx = -1;
    r.count = '0;
    for (int i = 0; i < ssac_pkg::TABLE_ENTRIES; i++) begin
      if (key_used[i] && key_addr[i] == addr && hit < 0) hit = i;
      if (!key_used[i] && free_idx < 0) free_idx = i;
    end
    if (rd) begin
      if (hit >= 0) begin
        r.status = ssac_pkg::ST_READ_HIT;
        r.count = key_count[hit];
      end else begin
        r.status = ssac_pkg::ST_READ_MISS;
      end
    end else if ((rnd & ((32'd1 << shift_q) - 32'd1)) != 32'd0) begin
      r.status = ssac_pkg::ST_NOT_SAMPLED;
    end else if (len < ssac_pkg::MIN_FRAME_BYTES) begin
      r.status = ssac_pkg::ST_SHORT;
    end else if (hit >= 0) begin
      key_count[hit] = key_count[hit] + 64'd1;
      r.status = ssac_pkg::ST_INCREMENTED;
      r.count = key_count[hit];
    end else if (free_idx >= 0) begin
      key_used[free_idx] = 1'b1;
      key_addr[free_idx] = addr;
      key_count[free_idx] = 64'd1;
      used_cnt++;
      r.status = ssac_pkg::ST_INSERTED;
      r.count = 64'd1;
    end else begin
      r.status = ssac_pkg::ST_FULL;
    end
    return r;
  endfunction

  // Push one word; a random gap before it, per the current idle setting.
  task automatic send_word(logic rd, logic [31:0] rnd, logic [15:0] len, logic [31:0] addr);
    if ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    push <= 1'b1;
    req_type <= rd;
    random_word <= rnd;
    frame_length <= len;
    source_address <= addr;
    do @(posedge clk); while (full);
    expected_q.push_back(count_word(rd, rnd, len, addr));
    n_sent++;
  endtask

  task automatic drain;
    push <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (2 * used_cnt + 10) @(posedge clk);
  endtask

  task automatic write_shift(logic [4:0] value);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    shift_q = value;
  endtask

  always @(posedge clk) begin
    if (!rst && pop && !empty) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected word status=%0d count=%0h", $time, status, count_value);
        errors++;
      end else begin
        if (status !== expected_q[0].status) begin
          $display("%0t: status expected %0d actual %0d", $time, expected_q[0].status,
                   status);
          errors++;
        end
        if (count_value !== expected_q[0].count) begin
          $display("%0t: count expected %0h actual %0h", $time, expected_q[0].count,
                   count_value);
          errors++;
        end
        if (expected_q[0].status <= ssac_pkg::ST_READ_MISS) begin
          status_seen[expected_q[0].status]++;
        end
        void'(expected_q.pop_front());
        n_checked++;
      end
    end
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = 400;
    end
    if (hold_left > 0) begin
      hold_left--;
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic test_directed;
    send_word(1'b1, 32'h0, 16'h0, 32'h0);
    send_word(1'b0, 32'h0, 16'd34, 32'h0);
    send_word(1'b0, 32'h0, 16'd34, 32'h0);
    send_word(1'b1, 32'hFFFFFFFF, 16'hFFFF, 32'h0);
    send_word(1'b0, 32'h0, 16'd33, 32'h5);
    send_word(1'b0, 32'h0, 16'h0, 32'hFFFFFFFF);
    send_word(1'b0, 32'h8, 16'hFFFF, 32'hFFFFFFFF);
    send_word(1'b0, 32'h1, 16'd100, 32'h0);
    send_word(1'b0, 32'hFFFFFFFF, 16'd100, 32'h0);
    send_word(1'b1, 32'h0, 16'h0, 32'hFFFFFFFF);
    write_shift(5'd0);
    send_word(1'b0, 32'hFFFFFFFF, 16'd34, 32'hFFFFFFFF);
    send_word(1'b0, 32'hFFFFFFFF, 16'd12, 32'h1);
    write_shift(5'd31);
    send_word(1'b0, 32'h40000000, 16'd60, 32'h0);
    send_word(1'b0, 32'h80000000, 16'd60, 32'h0);
    send_word(1'b0, 32'h0, 16'd60, 32'h0);
    send_word(1'b1, 32'h0, 16'h0, 32'h0);
  endtask

  task automatic send_random(int count);
    logic        rd;
    logic [31:0] rnd;
    logic [15:0] len;
    logic [31:0] addr;
    for (int i = 0; i < count; i++) begin
      rd = ($urandom_range(3) == 0);
      rnd = $urandom;
      if ($urandom_range(2) != 0) rnd = rnd & ~((32'd1 << shift_q) - 32'd1);
      case ($urandom_range(5))
        0: len = 16'($urandom_range(33));
        1: len = 16'd34;
        2: len = 16'($urandom);
        default: len = 16'($urandom_range(1518, 34));
      endcase
      addr = ($urandom_range(19) == 0) ? $urandom : addr_pool[$urandom_range(23)];
      send_word(rd, rnd, len, addr);
    end
  endtask

  task automatic test_random_traffic;
    int pct [3][2] = '{'{20, 49}, '{49, 20}, '{0, 0}};
    for (int m = 0; m < 3; m++) begin
      send_idle_pct = pct[m][0];
      recv_idle_pct = pct[m][1];
      for (int p = 0; p < 4; p++) begin
        write_shift(5'($urandom_range(3)));
        send_random(15);
      end
    end
  endtask

  task automatic test_backpressure;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_shift(5'd1);
    hold_req <= hold_req + 1;
    send_random(40);
    // Sender stops here until every outstanding word has come back.
    push <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    send_random(20);
  endtask

  task automatic test_full_table;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_shift(5'd0);
    while (used_cnt < ssac_pkg::TABLE_ENTRIES) send_word(1'b0, $urandom, 16'd64, $urandom);
    send_word(1'b0, 32'h0, 16'd64, 32'h12345678 ^ $urandom);
    send_word(1'b0, 32'h0, 16'd64, key_addr[ssac_pkg::TABLE_ENTRIES - 1]);
    send_word(1'b1, 32'h0, 16'd64, key_addr[0]);
    send_word(1'b0, 32'h0, 16'd20, 32'h0);
    write_shift(5'd3);
  endtask

  initial begin
    rst = 1'b1;
    push = 1'b0;
    pop = 1'b0;
    req_type = 1'b0;
    random_word = '0;
    frame_length = '0;
    source_address = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    errors = 0;
    n_sent = 0;
    n_checked = 0;
    hold_req = 0;
    hold_seen = 0;
    hold_left = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    shift_q = ssac_pkg::SHIFT_RESET;
    used_cnt = 0;
    for (int i = 0; i < ssac_pkg::TABLE_ENTRIES; i++) begin
      key_used[i] = 1'b0;
      key_addr[i] = '0;
      key_count[i] = '0;
    end
    for (int i = 0; i < 7; i++) status_seen[i] = 0;
    addr_pool[0] = 32'h0;
    addr_pool[1] = 32'hFFFFFFFF;
    for (int i = 2; i < 24; i++) addr_pool[i] = $urandom;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_random_traffic();
    test_backpressure();
    test_full_table();
    drain();

    $display("%0d words sent, %0d checked; not sampled %0d, short %0d, incremented %0d,",
             n_sent, n_checked, status_seen[0], status_seen[1], status_seen[2]);
    $display("inserted %0d, table full %0d, read hit %0d, read miss %0d", status_seen[3],
             status_seen[4], status_seen[5], status_seen[6]);
    if (errors == 0) begin
      $display("** sampled_source_address_counter_top: PASSED **");
    end else begin
      $display("** sampled_source_address_counter_top: FAILED **");
    end
    $finish;
  end

endmodule

### sim.f
hw/rtl/ssac_pkg.sv
hw/rtl/ssac_front.sv
hw/rtl/ssac_back.sv
hw/rtl/ssac_out_q.sv
hw/rtl/sampled_source_address_counter_top.sv
sim/sampled_source_address_counter_top_test.sv
